[design/knnv_pkg.sv]
// ---------------------------------------------------------------------------
// knnv_pkg
// Shared constants and types for the k-nearest-neighbor vote block.
// ---------------------------------------------------------------------------
package knnv_pkg;

   localparam int MAX_TRAIN = 256;
   localparam int CNT_W     = $clog2(MAX_TRAIN + 1);
   localparam int DIST_W    = 32;
   localparam int LBL_W     = 16;
   localparam int VOTE_W    = 24;
   localparam int K_W       = 9;
   localparam int CTR_W     = 32;
   localparam int USED_W    = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 9;

   localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};
   localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_K_NEIGHBORS      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_DUPLICATES = 1'd1;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [LBL_W-1:0]  pos;
      logic [LBL_W-1:0]  neg;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic step;
   } tally_ctl_type;

endpackage

[design/knnv_cell.sv]
// ---------------------------------------------------------------------------
// knnv_cell
// One slot of the sorted neighbor chain: parallel insert and shift toward head.
// ---------------------------------------------------------------------------
module knnv_cell (
   input  logic                   clock,
   input  knnv_pkg::cell_ctl_type ctl,
   input  knnv_pkg::entry_type    new_entry,
   input  knnv_pkg::entry_type    prev_entry,
   input  logic                   prev_gt,
   input  knnv_pkg::entry_type    next_entry,
   input  logic                   occupied,
   input  logic                   at_fill,
   output knnv_pkg::entry_type    entry,
   output logic                   gt
);
   import knnv_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   // slot holds a farther entry than the incoming item
   assign gt    = occupied && (data_ff.distance > new_entry.distance);
   assign entry = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = next_entry;
      end else if (ctl.insert) begin
         if (prev_gt) begin
            data_in = prev_entry;
         end else if (gt || at_fill) begin
            data_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[design/knnv_tally.sv]
// ---------------------------------------------------------------------------
// knnv_tally
// Vote accumulator fed from the head of the chain, with the stop test.
// ---------------------------------------------------------------------------
module knnv_tally (
   input  logic                            clock,
   input  knnv_pkg::tally_ctl_type         ctl,
   input  knnv_pkg::entry_type             head,
   input  logic [knnv_pkg::K_W-1:0]        k_neighbors,
   input  logic                            count_duplicates,
   output logic [knnv_pkg::VOTE_W-1:0]     pos_votes,
   output logic [knnv_pkg::VOTE_W-1:0]     neg_votes,
   output logic                            stop
);
   import knnv_pkg::*;

   logic [VOTE_W-1:0] pos_ff, pos_in;
   logic [VOTE_W-1:0] neg_ff, neg_in;
   logic [DIST_W-1:0] last_d_ff, last_d_in;
   logic [VOTE_W:0]   total;
   logic [VOTE_W:0]   pos_sum;
   logic [VOTE_W:0]   neg_sum;
   logic [LBL_W-1:0]  pos_add;
   logic [LBL_W-1:0]  neg_add;

   assign total = {1'b0, pos_ff} + {1'b0, neg_ff};
   assign stop  = (total >= (VOTE_W+1)'(k_neighbors)) && (head.distance != last_d_ff);

   always_comb begin
      if (count_duplicates) begin
         pos_add = head.pos;
         neg_add = head.neg;
      end else begin
         pos_add = LBL_W'(head.pos != '0);
         neg_add = LBL_W'(head.neg != '0);
      end
      pos_sum = {1'b0, pos_ff} + (VOTE_W+1)'(pos_add);
      neg_sum = {1'b0, neg_ff} + (VOTE_W+1)'(neg_add);

      pos_in    = pos_ff;
      neg_in    = neg_ff;
      last_d_in = last_d_ff;
      if (ctl.clear) begin
         pos_in    = '0;
         neg_in    = '0;
         last_d_in = '0;
      end else if (ctl.step) begin
         pos_in    = pos_sum[VOTE_W] ? VOTE_MAX : pos_sum[VOTE_W-1:0];
         neg_in    = neg_sum[VOTE_W] ? VOTE_MAX : neg_sum[VOTE_W-1:0];
         last_d_in = head.distance;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      neg_ff    <= neg_in;
      last_d_ff <= last_d_in;
   end

   assign pos_votes = pos_ff;
   assign neg_votes = neg_ff;

endmodule

[design/knnv_top.sv]
// ---------------------------------------------------------------------------
// knn_vote_with_ties
// k-nearest-neighbor majority vote over a sorted chain of neighbor cells.
// ---------------------------------------------------------------------------
// An item that is not the last of a query is inserted into the sorted cell
// chain at the accept edge and busy stays low, so such items may arrive
// every cycle. An item with last_entry set is also inserted, then busy rises
// while the chain shifts its nearest entry into the vote accumulator once per
// cycle (the walk), until all stored neighbors are used or at least k votes
// are counted and the head distance differs from the last one counted. The
// result is shown for exactly one cycle on rsp_valid at the end of the walk
// and cannot be held off; the confusion counters and vote fields stay put
// until the next query's vote. An item arriving with all MAX_TRAIN cells
// filled is not stored. csr_ready is always high; write registers only while busy is low.
// ---------------------------------------------------------------------------
module knn_vote_with_ties (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [knnv_pkg::DIST_W-1:0]       req_distance,
   input  logic [knnv_pkg::LBL_W-1:0]        req_pos_count,
   input  logic [knnv_pkg::LBL_W-1:0]        req_neg_count,
   input  logic                              req_true_label,
   input  logic                              req_last_entry,
   output logic                              rsp_valid,
   output logic                              rsp_pred_positive,
   output logic [knnv_pkg::VOTE_W-1:0]       rsp_pos_votes,
   output logic [knnv_pkg::VOTE_W-1:0]       rsp_neg_votes,
   output logic [knnv_pkg::USED_W-1:0]       rsp_neighbors_used,
   output logic [knnv_pkg::CTR_W-1:0]        rsp_true_pos,
   output logic [knnv_pkg::CTR_W-1:0]        rsp_false_pos,
   output logic [knnv_pkg::CTR_W-1:0]        rsp_true_neg,
   output logic [knnv_pkg::CTR_W-1:0]        rsp_false_neg,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [knnv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [knnv_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import knnv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             dup_ff, dup_in;
   logic             truth_ff, truth_in;
   logic             pred_ff, pred_in;
   logic             valid_ff, valid_in;
   logic [CTR_W-1:0] tp_ff, tp_in;
   logic [CTR_W-1:0] fp_ff, fp_in;
   logic [CTR_W-1:0] tn_ff, tn_in;
   logic [CTR_W-1:0] fn_ff, fn_in;

   logic             accept;
   logic             do_insert;
   logic             walk_done;
   logic             stop;
   logic             pred;
   logic [31:0]      walk_wide;
   logic [VOTE_W-1:0] pos_votes;
   logic [VOTE_W-1:0] neg_votes;

   entry_type        new_entry;
   entry_type        cells [MAX_TRAIN];
   logic             gts [MAX_TRAIN];
   cell_ctl_type     cell_ctl;
   tally_ctl_type    tally_ctl;

   assign accept    = start && !busy;
   assign do_insert = accept && (fill_ff != CNT_W'(MAX_TRAIN));
   assign walk_done = (walk_ff == fill_ff) || stop;

   assign new_entry.distance = req_distance;
   assign new_entry.pos      = req_pos_count;
   assign new_entry.neg      = req_neg_count;

   assign cell_ctl.insert  = do_insert;
   assign cell_ctl.shift   = (state_ff == ST_WALK) && !walk_done;
   assign tally_ctl.clear  = accept && req_last_entry;
   assign tally_ctl.step   = cell_ctl.shift;

   // sorted chain, nearest entry at slot zero
   for (genvar i = 0; i < MAX_TRAIN; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_g;

      if (i == 0) begin : g_head
         assign prev_e = new_entry;
         assign prev_g = 1'b0;
      end else begin : g_body
         assign prev_e = cells[i-1];
         assign prev_g = gts[i-1];
      end

      if (i == MAX_TRAIN - 1) begin : g_tail
         assign next_e = cells[i];
      end else begin : g_mid
         assign next_e = cells[i+1];
      end

      knnv_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .prev_gt    (prev_g),
         .next_entry (next_e),
         .occupied   (fill_ff > CNT_W'(i)),
         .at_fill    (fill_ff == CNT_W'(i)),
         .entry      (cells[i]),
         .gt         (gts[i])
      );
   end

   knnv_tally u_tally (
      .clock            (clock),
      .ctl              (tally_ctl),
      .head             (cells[0]),
      .k_neighbors      (k_ff),
      .count_duplicates (dup_ff),
      .pos_votes        (pos_votes),
      .neg_votes        (neg_votes),
      .stop             (stop)
   );

   // 2*pos > pos+neg reduces to pos > neg
   assign pred = pos_votes > neg_votes;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      walk_in  = walk_ff;
      k_in     = k_ff;
      dup_in   = dup_ff;
      truth_in = truth_ff;
      pred_in  = pred_ff;
      valid_in = 1'b0;
      tp_in    = tp_ff;
      fp_in    = fp_ff;
      tn_in    = tn_ff;
      fn_in    = fn_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_K_NEIGHBORS:      k_in   = csr_wdata[K_W-1:0];
            CSR_COUNT_DUPLICATES: dup_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (do_insert) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            if (accept && req_last_entry) begin
               truth_in = req_true_label;
               walk_in  = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               pred_in  = pred;
               valid_in = 1'b1;
               fill_in  = '0;
               state_in = ST_IDLE;
               if (truth_ff) begin
                  if (pred) tp_in = tp_ff + CTR_W'(1);
                  else      fn_in = fn_ff + CTR_W'(1);
               end else begin
                  if (pred) fp_in = fp_ff + CTR_W'(1);
                  else      tn_in = tn_ff + CTR_W'(1);
               end
            end else begin
               walk_in = walk_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         walk_ff  <= '0;
         k_ff     <= K_W'(1);
         dup_ff   <= 1'b1;
         valid_ff <= 1'b0;
         pred_ff  <= 1'b0;
         tp_ff    <= '0;
         fp_ff    <= '0;
         tn_ff    <= '0;
         fn_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         walk_ff  <= walk_in;
         k_ff     <= k_in;
         dup_ff   <= dup_in;
         valid_ff <= valid_in;
         pred_ff  <= pred_in;
         tp_ff    <= tp_in;
         fp_ff    <= fp_in;
         tn_ff    <= tn_in;
         fn_ff    <= fn_in;
      end
   end

   always_ff @(posedge clock) begin
      truth_ff <= truth_in;
   end

   assign walk_wide = 32'(walk_ff);

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = valid_ff;
   assign rsp_pred_positive  = pred_ff;
   assign rsp_pos_votes      = pos_votes;
   assign rsp_neg_votes      = neg_votes;
   assign rsp_neighbors_used = (walk_wide > 32'(USED_MAX)) ? USED_MAX
                                                           : walk_wide[USED_W-1:0];
   assign rsp_true_pos       = tp_ff;
   assign rsp_false_pos      = fp_ff;
   assign rsp_true_neg       = tn_ff;
   assign rsp_false_neg      = fn_ff;

endmodule
